[sv/dht_pkg.sv]
// Shared types, field widths and codes for the double-hashing table.
`default_nettype none
package dht_pkg;

    localparam int KEY_W    = 31;
    localparam int VALUE_W  = 64;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;
    localparam int DIV_W    = 17;

    localparam int CAPACITY_DEF   = 1024;
    localparam int STEP_PRIME_DEF = 1021;
    localparam int VALUE_BITS_DEF = 64;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic DIV_SEL_CAP  = 1'b0;
    localparam logic DIV_SEL_STEP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  found_value;
        logic [SLOT_W-1:0]   slot;
    } t_out_beat;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
        logic             sel;
    } t_div_req;

endpackage
`default_nettype wire

[sv/dht_divider.sv]
// Shared remainder unit: reciprocal multiply and back-multiply on one multiplier.
`default_nettype none
module dht_divider #(
    parameter int CAPACITY   = dht_pkg::CAPACITY_DEF,
    parameter int STEP_PRIME = dht_pkg::STEP_PRIME_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dht_pkg::t_div_req             i_req,
    output logic                               o_done,
    output logic [dht_pkg::DIV_W-1:0]          o_rem
);

    localparam int KW      = dht_pkg::KEY_W;
    localparam int DW      = dht_pkg::DIV_W;
    localparam int MW      = KW + 1;
    localparam int SH_CAP  = KW + $clog2(CAPACITY);
    localparam int SH_STEP = KW + $clog2(STEP_PRIME);

    localparam logic [MW-1:0] M_CAP  =
        MW'(((64'd1 << SH_CAP) + 64'(CAPACITY - 1)) / 64'(CAPACITY));
    localparam logic [MW-1:0] M_STEP =
        MW'(((64'd1 << SH_STEP) + 64'(STEP_PRIME - 1)) / 64'(STEP_PRIME));

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_RECIP = 2'd1;
    localparam logic [1:0] PH_BACK  = 2'd2;
    localparam logic [1:0] PH_SUB   = 2'd3;

    logic [1:0]      r_phase;
    logic            r_done;
    logic            r_sel;
    logic [KW-1:0]   r_x;
    logic [2*MW-1:0] r_prod;
    logic [DW-1:0]   r_rem;
    logic [MW-1:0]   quo;
    logic [MW-1:0]   mul_a;
    logic [MW-1:0]   mul_b;
    logic [2*MW-1:0] product;

    always_comb begin
        quo = (r_sel == dht_pkg::DIV_SEL_CAP) ? MW'(r_prod >> SH_CAP) :
                                                MW'(r_prod >> SH_STEP);
        if (r_phase == PH_RECIP) begin
            mul_a = {1'b0, r_x};
            mul_b = (r_sel == dht_pkg::DIV_SEL_CAP) ? M_CAP : M_STEP;
        end else begin
            mul_a = quo;
            mul_b = (r_sel == dht_pkg::DIV_SEL_CAP) ? MW'(CAPACITY) : MW'(STEP_PRIME);
        end
        product = (2*MW)'(mul_a) * (2*MW)'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_phase <= PH_RECIP;
            end else begin
                unique case (r_phase)
                    PH_RECIP: begin
                        r_phase <= PH_BACK;
                    end
                    PH_BACK: begin
                        r_phase <= PH_SUB;
                    end
                    PH_SUB: begin
                        r_phase <= PH_IDLE;
                        r_done  <= 1'b1;
                    end
                    default: begin
                        r_phase <= PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_req.dividend;
            r_sel <= i_req.sel;
        end else if (r_phase == PH_RECIP || r_phase == PH_BACK) begin
            r_prod <= product;
        end else if (r_phase == PH_SUB) begin
            r_rem <= r_x[DW-1:0] - r_prod[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

[sv/dht_store.sv]
// Slot memory: occupied bit, key and payload per slot, registered read.
`default_nettype none
module dht_store #(
    parameter int DEPTH = dht_pkg::CAPACITY_DEF,
    parameter int VW    = dht_pkg::VALUE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  wire logic                         i_wr_used,
    input  wire logic [dht_pkg::KEY_W-1:0]    i_wr_key,
    input  wire logic [VW-1:0]                i_wr_value,
    input  wire logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic                              o_rd_used,
    output logic [dht_pkg::KEY_W-1:0]         o_rd_key,
    output logic [VW-1:0]                     o_rd_value
);

    localparam int KW = dht_pkg::KEY_W;
    localparam int WW = 1 + KW + VW;

    logic [WW-1:0] mem [DEPTH];
    logic [WW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_used, i_wr_key, i_wr_value};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_rd_addr];
    end

    assign o_rd_used  = r_rdata[WW-1];
    assign o_rd_key   = r_rdata[WW-2 -: KW];
    assign o_rd_value = r_rdata[VW-1:0];

endmodule
`default_nettype wire

[sv/double_hash_table_top.sv]
// Top level: double-hashing table sequencer, shared remainder unit and slot memory.
//
//  channel | dir | handshake                 | payload
//  in      | in  | i_in_valid / o_in_ready   | i_in_beat  (cmd, key, value)
//  out     | out | o_out_valid / i_out_ready | o_out_beat (status, found_value, slot)
//
// One beat makes three passes through the shared remainder unit (key mod CAPACITY,
// key mod STEP_PRIME, step mod CAPACITY), then a memory read and a check per probe,
// then loads the result into the output register, and ready returns with it.
// After reset a clearing pass empties every slot; no beat is taken meanwhile.
// A finished result waits in the output register while the next beat is accepted;
// a second result holds until that one is taken.
`default_nettype none
module double_hash_table_top #(
    parameter int CAPACITY   = dht_pkg::CAPACITY_DEF,
    parameter int STEP_PRIME = dht_pkg::STEP_PRIME_DEF,
    parameter int VALUE_BITS = dht_pkg::VALUE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire dht_pkg::t_in_beat  i_in_beat,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output dht_pkg::t_out_beat      o_out_beat
);

    localparam int SW    = $clog2(CAPACITY);
    localparam int KW    = dht_pkg::KEY_W;
    localparam int DW    = dht_pkg::DIV_W;
    localparam int OVW   = dht_pkg::VALUE_W;
    localparam int OSW   = dht_pkg::SLOT_W;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_MOD_CAP  = 3'd2;
    localparam logic [2:0] S_MOD_STEP = 3'd3;
    localparam logic [2:0] S_MOD_SCAP = 3'd4;
    localparam logic [2:0] S_READ     = 3'd5;
    localparam logic [2:0] S_CHECK    = 3'd6;
    localparam logic [2:0] S_EMIT     = 3'd7;

    logic [2:0]              r_state, n_state;
    logic [SW-1:0]           r_slot, n_slot;
    logic [SW-1:0]           r_probe, n_probe;
    logic [SW-1:0]           r_stepm, n_stepm;
    logic                    r_cmd;
    logic [KW-1:0]           r_key;
    logic [VALUE_BITS-1:0]   r_value;
    dht_pkg::t_out_beat      r_res, n_res;
    dht_pkg::t_out_beat      r_out;
    logic                    r_out_valid;

    dht_pkg::t_div_req       div_req;
    logic                    div_done;
    logic [DW-1:0]           div_rem;
    logic [DW-1:0]           step;

    logic                    wr_en;
    logic                    rd_used;
    logic [KW-1:0]           rd_key;
    logic [VALUE_BITS-1:0]   rd_value;

    logic [SW:0]             slot_sum;
    logic [SW-1:0]           slot_next;
    logic                    last_probe;
    logic                    in_fire;
    logic                    out_load;

    dht_divider #(
        .CAPACITY   (CAPACITY),
        .STEP_PRIME (STEP_PRIME)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    dht_store #(
        .DEPTH (CAPACITY),
        .VW    (VALUE_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_slot),
        .i_wr_used  (r_state != S_CLEAR),
        .i_wr_key   (r_key),
        .i_wr_value (r_value),
        .i_rd_addr  (r_slot),
        .o_rd_used  (rd_used),
        .o_rd_key   (rd_key),
        .o_rd_value (rd_value)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign step       = DW'(STEP_PRIME) - div_rem;
    assign slot_sum   = {1'b0, r_slot} + {1'b0, r_stepm};
    assign slot_next  = (slot_sum >= (SW + 1)'(CAPACITY)) ?
                        SW'(slot_sum - (SW + 1)'(CAPACITY)) : slot_sum[SW-1:0];
    assign last_probe = (r_probe == SW'(CAPACITY - 1));
    assign wr_en      = (r_state == S_CLEAR) ||
                        (r_state == S_CHECK && r_cmd == dht_pkg::CMD_INSERT && !rd_used);
    assign out_load   = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = i_in_beat.key;
        div_req.sel      = dht_pkg::DIV_SEL_CAP;
        unique case (r_state)
            S_IDLE: begin
                div_req.start = in_fire;
            end
            S_MOD_CAP: begin
                div_req.start    = div_done;
                div_req.dividend = r_key;
                div_req.sel      = dht_pkg::DIV_SEL_STEP;
            end
            S_MOD_STEP: begin
                div_req.start    = div_done;
                div_req.dividend = KW'(step);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_probe = r_probe;
        n_stepm = r_stepm;
        n_res   = r_res;
        unique case (r_state)
            S_CLEAR: begin
                n_slot = r_slot + 1'b1;
                if (r_slot == SW'(CAPACITY - 1)) begin
                    n_slot  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_MOD_CAP;
                end
            end
            S_MOD_CAP: begin
                if (div_done) begin
                    n_slot  = div_rem[SW-1:0];
                    n_state = S_MOD_STEP;
                end
            end
            S_MOD_STEP: begin
                if (div_done) begin
                    n_state = S_MOD_SCAP;
                end
            end
            S_MOD_SCAP: begin
                if (div_done) begin
                    n_stepm = div_rem[SW-1:0];
                    n_probe = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_res.found_value = '0;
                n_res.slot        = '0;
                if (!rd_used) begin
                    n_state = S_EMIT;
                    if (r_cmd == dht_pkg::CMD_INSERT) begin
                        n_res.status = dht_pkg::ST_INSERTED;
                        n_res.slot   = OSW'(r_slot);
                    end else begin
                        n_res.status = dht_pkg::ST_NOT_FOUND;
                    end
                end else if (r_cmd == dht_pkg::CMD_SEARCH && rd_key == r_key) begin
                    n_state           = S_EMIT;
                    n_res.status      = dht_pkg::ST_FOUND;
                    n_res.found_value = OVW'(rd_value);
                    n_res.slot        = OSW'(r_slot);
                end else if (last_probe) begin
                    n_state      = S_EMIT;
                    n_res.status = (r_cmd == dht_pkg::CMD_INSERT) ?
                                   dht_pkg::ST_FULL : dht_pkg::ST_NOT_FOUND;
                end else begin
                    n_probe = r_probe + 1'b1;
                    n_slot  = slot_next;
                    n_state = S_READ;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
        r_stepm <= n_stepm;
        r_res   <= n_res;
        if (in_fire) begin
            r_cmd   <= i_in_beat.cmd;
            r_key   <= i_in_beat.key;
            r_value <= VALUE_BITS'(i_in_beat.value);
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

`ifndef SYNTH
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_in_ready)
        else $error("beat accepted before clearing pass");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_MOD_CAP || r_state == S_MOD_STEP ||
                      r_state == S_MOD_SCAP))
        else $error("remainder unit finished outside a divide state");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_slot < CAPACITY && r_stepm < CAPACITY))
        else $error("probe slot out of range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_MOD_CAP))
        else $error("accepted beat did not start the hash");
`endif

endmodule
`default_nettype wire
